### rtl/core/utpc_pkg.sv
// Shared constants, types and the ones-complement fold for the pseudo header checksum block.
package utpc_pkg;

    localparam int unsigned WordWidth = 16;
    localparam int unsigned AddrWidth = 32;
    localparam int unsigned ProtoWidth = 8;
    localparam int unsigned CfgIndexWidth = 2;
    // eight 16-bit operands fit in 19 bits
    localparam int unsigned SumWidth = WordWidth + 3;

    localparam logic [CfgIndexWidth-1:0] CFG_SOURCE_ADDRESS = 2'd0;
    localparam logic [CfgIndexWidth-1:0] CFG_DESTINATION_ADDRESS = 2'd1;
    localparam logic [CfgIndexWidth-1:0] CFG_PROTOCOL_NUMBER = 2'd2;

    localparam logic [ProtoWidth-1:0] PROTOCOL_RESET = 8'd17;
    localparam logic [WordWidth-1:0] WORD_MAX = 16'hFFFF;

    // segment snapshot taken at the closing item
    typedef struct packed {
        logic [WordWidth-1:0] data_sum;
        logic [WordWidth-1:0] pad_word;
        logic [WordWidth-1:0] byte_count;
    } utpc_close_t;

    // ones-complement 16-bit add with end-around carry
    function automatic logic [WordWidth-1:0] oc_add(
        input logic [WordWidth-1:0] a,
        input logic [WordWidth-1:0] b
    );
        logic [WordWidth:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[WordWidth-1:0] + {{(WordWidth-1){1'b0}}, s[WordWidth]};
    endfunction

    // fold a binary sum of up to eight words into 16 bits
    function automatic logic [WordWidth-1:0] oc_fold(input logic [SumWidth-1:0] t);
        logic [WordWidth:0] a;
        a = {1'b0, t[WordWidth-1:0]} + {{(WordWidth-2){1'b0}}, t[SumWidth-1:WordWidth]};
        return a[WordWidth-1:0] + {{(WordWidth-1){1'b0}}, a[WordWidth]};
    endfunction

endpackage

### rtl/core/utpc_accum.sv
// Running word sum, odd byte holding and byte count of the segment in flight.
module utpc_accum (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       accept,
    input  logic [7:0]                 data_byte,
    input  logic                       has_byte,
    input  logic                       last_item,
    output utpc_pkg::utpc_close_t      close_info
);
    import utpc_pkg::*;

    logic [WordWidth-1:0] running_sum_reg, running_sum_next;
    logic [7:0]           pending_high_byte_reg, pending_high_byte_next;
    logic                 odd_byte_waiting_reg, odd_byte_waiting_next;
    logic [WordWidth-1:0] byte_count_reg, byte_count_next;

    always_comb begin
        running_sum_next = running_sum_reg;
        pending_high_byte_next = pending_high_byte_reg;
        odd_byte_waiting_next = odd_byte_waiting_reg;
        byte_count_next = byte_count_reg;
        if (has_byte) begin
            if (odd_byte_waiting_reg) begin
                running_sum_next = oc_add(running_sum_reg, {pending_high_byte_reg, data_byte});
                pending_high_byte_next = 8'd0;
                odd_byte_waiting_next = 1'b0;
            end else begin
                pending_high_byte_next = data_byte;
                odd_byte_waiting_next = 1'b1;
            end
            if (byte_count_reg != WORD_MAX) begin
                byte_count_next = byte_count_reg + 16'd1;
            end
        end
    end

    // a trailing odd byte is padded with a zero low byte
    assign close_info.data_sum = running_sum_next;
    assign close_info.pad_word = odd_byte_waiting_next ? {pending_high_byte_next, 8'd0} : '0;
    assign close_info.byte_count = byte_count_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_sum_reg <= '0;
            pending_high_byte_reg <= '0;
            odd_byte_waiting_reg <= 1'b0;
            byte_count_reg <= '0;
        end else if (accept) begin
            if (last_item) begin
                running_sum_reg <= '0;
                pending_high_byte_reg <= '0;
                odd_byte_waiting_reg <= 1'b0;
                byte_count_reg <= '0;
            end else begin
                running_sum_reg <= running_sum_next;
                pending_high_byte_reg <= pending_high_byte_next;
                odd_byte_waiting_reg <= odd_byte_waiting_next;
                byte_count_reg <= byte_count_next;
            end
        end
    end

endmodule

### rtl/core/udp_tcp_pseudo_header_checksum.sv
// Top level: UDP/TCP checksum over segment bytes plus the IPv4 pseudo header.
//
// Usage: segment bytes enter one per item on the s_ stream, first byte first.
// s_tuser (has_byte) marks whether s_tdata carries a byte; s_tlast closes the
// segment, and an item with s_tuser low and s_tlast high closes it without a
// byte. Each closing item yields one m_ item with the complemented checksum
// and the byte count; other items yield nothing.
// Addresses and protocol number come from the write port (cfg_index 0, 1, 2)
// and are to be written only while no segment is in progress; the block itself does not enforce this.
// Throughput: one item per cycle while s_tready is high, set by the single
// 16-bit end-around add of the running sum. The closing register loads when
// the closing item is accepted, and the pseudo header add and fold then feed
// the output register, which drives m_tvalid and m_tdata.
// Reset (aresetn low, synchronous) clears the running sum, the byte count and
// both pipeline valids; addresses go to zero and the protocol number to 17.
// When m_tready is low the result holds in the output register; further
// non-closing items are still taken, and one closing item waits in the
// closing register before s_tready drops.
module udp_tcp_pseudo_header_checksum (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,     // [7:0] data_byte
    input  logic        s_tuser,     // [0] has_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,     // [15:0] checksum, [31:16] segment_length
    input  logic        cfg_we,
    input  logic [utpc_pkg::CfgIndexWidth-1:0] cfg_index,
    input  logic [31:0] cfg_wdata
);
    import utpc_pkg::*;

    logic [AddrWidth-1:0]  source_address_reg;
    logic [AddrWidth-1:0]  destination_address_reg;
    logic [ProtoWidth-1:0] protocol_number_reg;

    logic        accept;
    logic        advance;
    utpc_close_t close_info;
    utpc_close_t close_reg;
    logic        close_valid_reg;
    logic        m_tvalid_reg;
    logic [WordWidth-1:0] checksum_reg, checksum_next;
    logic [WordWidth-1:0] length_reg;
    logic [SumWidth-1:0]  total;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            source_address_reg <= '0;
            destination_address_reg <= '0;
            protocol_number_reg <= PROTOCOL_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_SOURCE_ADDRESS: source_address_reg <= cfg_wdata;
                CFG_DESTINATION_ADDRESS: destination_address_reg <= cfg_wdata;
                CFG_PROTOCOL_NUMBER: protocol_number_reg <= cfg_wdata[ProtoWidth-1:0];
                default: ;
            endcase
        end
    end

    assign advance = !m_tvalid_reg || m_tready;
    assign s_tready = !close_valid_reg || advance;
    assign accept = s_tvalid && s_tready;

    utpc_accum u_accum (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .data_byte  (s_tdata),
        .has_byte   (s_tuser),
        .last_item  (s_tlast),
        .close_info (close_info)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            close_valid_reg <= 1'b0;
        end else if (advance || !close_valid_reg) begin
            close_valid_reg <= accept && s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && s_tlast) begin
            close_reg <= close_info;
        end
    end

    // binary sum of all eight words, folded afterwards: same as chained end-around adds
    always_comb begin
        total = {3'b000, close_reg.data_sum}
              + {3'b000, close_reg.pad_word}
              + {3'b000, source_address_reg[31:16]}
              + {3'b000, source_address_reg[15:0]}
              + {3'b000, destination_address_reg[31:16]}
              + {3'b000, destination_address_reg[15:0]}
              + {11'd0, protocol_number_reg}
              + {3'b000, close_reg.byte_count};
        checksum_next = ~oc_fold(total);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (advance) begin
            m_tvalid_reg <= close_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && close_valid_reg) begin
            checksum_reg <= checksum_next;
            length_reg <= close_reg.byte_count;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata = {length_reg, checksum_reg};

endmodule
